// File: rtl/cdq_pkg.sv
// ----------------------------------------------------------------------------
// Circular deque package
// Shared defaults, operation codes and status codes for the circular deque.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int CDQ_CAPACITY   = 16;
  localparam int CDQ_DATA_WIDTH = 32;

  typedef enum logic [1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_BACK  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_BACK   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

endpackage

// File: rtl/circular_deque_core.sv
// ----------------------------------------------------------------------------
// Circular deque core
// Fixed-capacity double-ended queue held in a single-port RAM.
// Pipeline: a taken request is held in the s1 stage, then moved to the result register.
// Throughput: one word per cycle when not stalled, set by the single RAM access per operation.
// Reset: pointers, count and handshake state clear; the RAM is not cleared.
// ----------------------------------------------------------------------------
module circular_deque_core
  import cdq_pkg::*;
#(
  parameter int CAPACITY   = CDQ_CAPACITY,
  parameter int DATA_WIDTH = CDQ_DATA_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  action,
  input  logic [31:0] push_value,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [1:0]  status,
  output logic [31:0] popped_value,
  output logic [4:0]  occupancy
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [AW-1:0] LAST    = AW'(CAPACITY - 1);
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  logic [AW-1:0] head, head_next;
  logic [AW-1:0] tail, tail_next;
  logic [CW-1:0] count, count_next;

  logic          s1_valid;
  status_t       s1_status;
  logic [4:0]    s1_occ;
  logic          s1_pop;

  logic          acc;
  logic          advance;
  logic          mem_we;
  logic          pop_ok;
  status_t       st;
  logic [AW-1:0] mem_addr;
  logic [AW-1:0] head_inc, head_dec, tail_inc, tail_dec;
  logic          full, empty;
  logic [63:0]   push_ext;
  logic [63:0]   rd_ext;
  logic [31:0]   occ_ext;
  logic [DATA_WIDTH-1:0] wdata;
  logic [DATA_WIDTH-1:0] rdata;

  assign advance   = s1_valid && (!res_valid || !res_stall);
  assign req_stall = s1_valid && res_valid && res_stall;
  assign acc       = req_valid && !req_stall;

  assign head_inc = (head == LAST) ? '0 : head + 1'b1;
  assign head_dec = (head == '0) ? LAST : head - 1'b1;
  assign tail_inc = (tail == LAST) ? '0 : tail + 1'b1;
  assign tail_dec = (tail == '0) ? LAST : tail - 1'b1;
  assign full     = (count == CAP_CNT);
  assign empty    = (count == '0);

  assign push_ext = {32'd0, push_value};
  assign wdata    = push_ext[DATA_WIDTH-1:0];
  assign rd_ext   = 64'(rdata);
  assign occ_ext  = 32'(count_next);

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    mem_addr   = head;
    mem_we     = 1'b0;
    pop_ok     = 1'b0;
    st         = ST_OK;
    unique case (action_t'(action))
      ACT_PUSH_FRONT: begin
        if (full) begin
          st = ST_OVERFLOW;
        end else begin
          head_next  = head_dec;
          mem_addr   = head_dec;
          mem_we     = 1'b1;
          count_next = count + 1'b1;
        end
      end
      ACT_PUSH_BACK: begin
        if (full) begin
          st = ST_OVERFLOW;
        end else begin
          tail_next  = tail_inc;
          mem_addr   = tail;
          mem_we     = 1'b1;
          count_next = count + 1'b1;
        end
      end
      ACT_POP_FRONT: begin
        if (empty) begin
          st = ST_UNDERFLOW;
        end else begin
          head_next  = head_inc;
          mem_addr   = head;
          pop_ok     = 1'b1;
          count_next = count - 1'b1;
        end
      end
      ACT_POP_BACK: begin
        if (empty) begin
          st = ST_UNDERFLOW;
        end else begin
          tail_next  = tail_dec;
          mem_addr   = tail_dec;
          pop_ok     = 1'b1;
          count_next = count - 1'b1;
        end
      end
      default: begin
        st = ST_OK;
      end
    endcase
  end

  cdq_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .en   (acc && !rst && (mem_we || pop_ok)),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(wdata),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (acc) begin
        head      <= head_next;
        tail      <= tail_next;
        count     <= count_next;
        s1_valid  <= 1'b1;
        s1_status <= st;
        s1_occ    <= occ_ext[4:0];
        s1_pop    <= pop_ok;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        res_valid    <= 1'b1;
        status       <= s1_status;
        occupancy    <= s1_occ;
        popped_value <= s1_pop ? rd_ext[31:0] : 32'd0;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_CNT)
    else $error("Element count exceeds capacity.");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (head == tail))
    else $error("Pointers disagree on an empty deque.");

  a_full_ptrs: assert property (@(posedge clk) disable iff (rst)
    (count == CAP_CNT) |-> (head == tail))
    else $error("Pointers disagree on a full deque.");

  a_rdata_hold: assert property (@(posedge clk) disable iff (rst)
    req_stall |=> $stable(rdata))
    else $error("Read data changed while the pending word was held.");

endmodule

// File: rtl/cdq_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle; read data is registered and holds between reads.
// ----------------------------------------------------------------------------
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// Circular deque core testbench
// Drives front and back pushes and pops into the deque and keeps a shadow copy
// of its contents. Every returned word is checked for status, popped value and
// occupancy. Both sides idle at random, and one receiver hold-off fills the
// pipeline so that the input stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import cdq_pkg::*;

  localparam int CYCLE_LIMIT = 500000;

  typedef struct {
    status_t     st;
    logic [31:0] value;
    logic [4:0]  occ;
  } deque_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  action_t     action = ACT_PUSH_FRONT;
  logic [31:0] push_value = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic [1:0]  status;
  logic [31:0] popped_value;
  logic [4:0]  occupancy;

  logic [31:0]   shadow_store [CDQ_CAPACITY];
  int            front_slot = 0;
  int            back_slot = 0;
  int            fill_level = 0;
  deque_result_t expected_results [$];

  int mismatch_count = 0;
  int cycle_count = 0;
  bit quiet_phase = 1'b0;
  int hold_request = 0;
  int hold_left = 0;
  int stall_left = 0;

  circular_deque_core uut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .action       (action),
    .push_value   (push_value),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .status       (status),
    .popped_value (popped_value),
    .occupancy    (occupancy)
  );

  always #10 clk = ~clk;

  function automatic deque_result_t apply_deque_op(input action_t a, input logic [31:0] v);
    deque_result_t r;
    r.st = ST_OK;
    r.value = '0;
    case (a)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (fill_level >= CDQ_CAPACITY) begin
          r.st = ST_OVERFLOW;
        end else if (a == ACT_PUSH_FRONT) begin
          front_slot = (front_slot == 0) ? CDQ_CAPACITY - 1 : front_slot - 1;
          shadow_store[front_slot] = v;
          fill_level++;
        end else begin
          shadow_store[back_slot] = v;
          back_slot = (back_slot == CDQ_CAPACITY - 1) ? 0 : back_slot + 1;
          fill_level++;
        end
      end
      default: begin
        if (fill_level == 0) begin
          r.st = ST_UNDERFLOW;
        end else if (a == ACT_POP_FRONT) begin
          r.value = shadow_store[front_slot];
          front_slot = (front_slot == CDQ_CAPACITY - 1) ? 0 : front_slot + 1;
          fill_level--;
        end else begin
          back_slot = (back_slot == 0) ? CDQ_CAPACITY - 1 : back_slot - 1;
          r.value = shadow_store[back_slot];
          fill_level--;
        end
      end
    endcase
    r.occ = 5'(fill_level);
    return r;
  endfunction

  function automatic int pick_send_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_phase || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 20);
  endfunction

  function automatic logic [31:0] random_value();
    case ($urandom_range(0, 19))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input action_t a, input logic [31:0] v);
    int gap;
    gap = pick_send_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    action <= a;
    push_value <= v;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    expected_results.push_back(apply_deque_op(a, v));
  endtask

  task automatic test_directed();
    send_word(ACT_POP_FRONT, 32'h1234_5678);
    send_word(ACT_POP_BACK, 32'hFFFF_FFFF);
    send_word(ACT_PUSH_FRONT, 32'h8000_0000);
    send_word(ACT_PUSH_FRONT, 32'h7FFF_FFFF);
    send_word(ACT_PUSH_BACK, 32'hFFFF_FFFF);
    send_word(ACT_PUSH_BACK, 32'h0000_0000);
    send_word(ACT_POP_BACK, 32'h0);
    send_word(ACT_POP_FRONT, 32'h0);
    send_word(ACT_POP_BACK, 32'h0);
    send_word(ACT_POP_BACK, 32'h0);
    send_word(ACT_POP_FRONT, 32'h0);
    send_word(ACT_PUSH_BACK, 32'h5555_5555);
    send_word(ACT_PUSH_BACK, 32'hAAAA_AAAA);
    send_word(ACT_POP_FRONT, 32'h0);
    send_word(ACT_POP_FRONT, 32'h0);
  endtask

  task automatic test_random(input int n_words);
    int done;
    int phase_len;
    int push_pct;
    action_t a;
    done = 0;
    while (done < n_words) begin
      phase_len = $urandom_range(10, 60);
      case ($urandom_range(0, 3))
        0: push_pct = 85;
        1: push_pct = 15;
        default: push_pct = 50;
      endcase
      quiet_phase = ($urandom_range(0, 5) == 0);
      for (int k = 0; k < phase_len; k++) begin
        if ($urandom_range(0, 99) < push_pct)
          a = $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
        else
          a = $urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT;
        send_word(a, random_value());
        done++;
      end
    end
    quiet_phase = 1'b0;
  endtask

  task automatic test_backpressure();
    action_t a;
    quiet_phase = 1'b1;
    hold_request = 200;
    for (int k = 0; k < 48; k++) begin
      a = action_t'($urandom_range(0, 3));
      send_word(a, random_value());
    end
    quiet_phase = 1'b0;
  endtask

  task automatic finish_run();
    req_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    mismatch_count += expected_results.size();
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  endtask

  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      res_stall <= 1'b1;
    end else if (quiet_phase) begin
      res_stall <= 1'b0;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4: begin
          stall_left = $urandom_range(0, 3);
          res_stall <= 1'b1;
        end
        5: begin
          stall_left = $urandom_range(8, 30);
          res_stall <= 1'b1;
        end
        default: res_stall <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin : result_check
    deque_result_t want;
    if (!rst && res_valid && !res_stall) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected word: status %0d value %h occupancy %0d",
                   status, popped_value, occupancy);
      end else begin
        want = expected_results.pop_front();
        if (status !== want.st || popped_value !== want.value || occupancy !== want.occ) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Mismatch: expected status %0d value %h occupancy %0d, got %0d %h %0d",
                     want.st, want.value, want.occ, status, popped_value, occupancy);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(1700);
    test_backpressure();
    finish_run();
  end

endmodule

// File: filelist.f
rtl/cdq_pkg.sv
rtl/cdq_ram.sv
rtl/circular_deque_core.sv
tb/tb.sv
